[design/fbn_pkg.sv]
package fbn_pkg;

  localparam int unsigned BIDX_W = 48;
  localparam int unsigned IDX_W  = 14;
  localparam int unsigned QUO_W  = 28;

  // Region codes
  localparam logic [2:0] REG_INODE  = 3'd0;
  localparam logic [2:0] REG_DIRECT0 = 3'd1;
  localparam logic [2:0] REG_DIRECT1 = 3'd2;
  localparam logic [2:0] REG_IND0   = 3'd3;
  localparam logic [2:0] REG_IND1   = 3'd4;
  localparam logic [2:0] REG_DIND   = 3'd5;
  localparam logic [2:0] REG_HOLE   = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] CFG_INODE_SLOTS = 2'd0;
  localparam logic [1:0] CFG_ADDRS_PER_NODE = 2'd1;
  localparam logic [1:0] CFG_CLUSTER_LOG = 2'd2;

  localparam logic [13:0] INODE_SLOTS_RST = 14'd923;
  localparam logic [13:0] ADDRS_PER_NODE_RST = 14'd1018;
  localparam logic [3:0]  CLUSTER_LOG_RST = 4'd0;
  localparam logic [3:0]  CLUSTER_LOG_MAX = 4'd8;

  // Item state as it moves down the pipeline. region stays REG_HOLE while
  // the range walk is still open.
  typedef struct packed {
    logic [2:0]        region;
    logic [BIDX_W-1:0] a;
    logic [QUO_W-1:0]  q;
    logic [IDX_W-1:0]  leaf;
  } pl_t;

endpackage

[design/file_block_index_to_node_path_top.sv]
// Block index to node-tree path translator.
//
// Input channel: block_index_i with in_valid_i / in_stall_o. Output channel:
// region_o, top_index_o, middle_index_o, leaf_index_o with out_valid_o /
// out_stall_i. An item moves at a clock edge where valid is high and stall
// is low. Every item gives exactly one result, in order.
//
// The pipeline has six range-walk stages (inode slots, two direct nodes,
// two indirect nodes, double-indirect limit), 28 restoring steps dividing
// the offset by the leaf capacity, and 14 steps dividing that quotient by
// the node size. One item enters per cycle unless the receiver stalls.
//
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall_o rises in the same cycle; nothing is dropped or repeated.
// Reset empties the pipeline and loads the configuration reset values.
// Config writes go through cfg_we_i / cfg_index_i / cfg_data_i and take
// effect for items accepted from the next cycle on; derived node limits
// settle in step with the stages that use them.
module file_block_index_to_node_path_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [47:0] block_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  region_o,
  output logic [13:0] top_index_o,
  output logic [13:0] middle_index_o,
  output logic [13:0] leaf_index_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i
);
  import fbn_pkg::*;

  localparam int unsigned N_FRONT = 6;
  localparam int unsigned N_DIV1  = QUO_W;
  localparam int unsigned N_DIV2  = IDX_W;

  // Configuration and derived limits
  logic [13:0] slots_q, npi_q, dpd_q, dpd_d;
  logic [3:0]  clog_q, clog_sat;
  logic [27:0] per_q, per_d;
  logic [41:0] lim_q, lim_d;
  logic [13:0] cmask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= INODE_SLOTS_RST;
      npi_q   <= ADDRS_PER_NODE_RST;
      clog_q  <= CLUSTER_LOG_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_INODE_SLOTS:    slots_q <= cfg_data_i;
        CFG_ADDRS_PER_NODE: npi_q   <= cfg_data_i;
        CFG_CLUSTER_LOG:    clog_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Leaf capacity: node size rounded down to the cluster size.
  always_comb begin
    clog_sat = (clog_q > CLUSTER_LOG_MAX) ? CLUSTER_LOG_MAX : clog_q;
    cmask    = (14'd1 << clog_sat) - 14'd1;
    dpd_d    = npi_q & ~cmask;
    per_d    = 28'(npi_q) * 28'(dpd_q);
    lim_d    = 42'(npi_q) * 42'(per_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpd_q <= ADDRS_PER_NODE_RST;
      per_q <= 28'(ADDRS_PER_NODE_RST) * 28'(ADDRS_PER_NODE_RST);
      lim_q <= 42'(ADDRS_PER_NODE_RST) * 42'(ADDRS_PER_NODE_RST)
               * 42'(ADDRS_PER_NODE_RST);
    end else begin
      dpd_q <= dpd_d;
      per_q <= per_d;
      lim_q <= lim_d;
    end
  end

  // Global advance: hold everything while a result waits on a stall.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Range walk
  logic        fv [0:N_FRONT];
  pl_t         fd [0:N_FRONT];
  logic [47:0] thr [0:N_FRONT-1];

  assign thr[0] = 48'(slots_q);
  assign thr[1] = 48'(dpd_q);
  assign thr[2] = 48'(dpd_q);
  assign thr[3] = 48'(per_q);
  assign thr[4] = 48'(per_q);
  assign thr[5] = 48'(lim_q);

  always_comb begin
    fv[0]        = in_valid_i;
    fd[0].region = REG_HOLE;
    fd[0].a      = block_index_i;
    fd[0].q      = '0;
    fd[0].leaf   = block_index_i[13:0];
  end

  for (genvar k = 0; k < N_FRONT; k++) begin : g_front
    fbn_front_stage #(.CODE(3'(k))) u_front (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (fv[k]),
      .data_i  (fd[k]),
      .thr_i   (thr[k]),
      .valid_o (fv[k+1]),
      .data_o  (fd[k+1])
    );
  end

  // Offset / leaf capacity
  logic dv1 [0:N_DIV1];
  pl_t  dd1 [0:N_DIV1];

  assign dv1[0] = fv[N_FRONT];
  assign dd1[0] = fd[N_FRONT];

  for (genvar k = 0; k < N_DIV1; k++) begin : g_div1
    fbn_div_stage #(.SHIFT(N_DIV1 - 1 - k)) u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (dv1[k]),
      .data_i    (dd1[k]),
      .divisor_i (dpd_q),
      .valid_o   (dv1[k+1]),
      .data_o    (dd1[k+1])
    );
  end

  // Remainder becomes the leaf (inode keeps its own); quotient divides next.
  logic dv2 [0:N_DIV2];
  pl_t  dd2 [0:N_DIV2];

  always_comb begin
    dv2[0]        = dv1[N_DIV1];
    dd2[0].region = dd1[N_DIV1].region;
    dd2[0].a      = 48'(dd1[N_DIV1].q);
    dd2[0].q      = '0;
    dd2[0].leaf   = (dd1[N_DIV1].region == REG_INODE) ? dd1[N_DIV1].leaf
                                                       : dd1[N_DIV1].a[13:0];
  end

  for (genvar k = 0; k < N_DIV2; k++) begin : g_div2
    fbn_div_stage #(.SHIFT(N_DIV2 - 1 - k)) u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (dv2[k]),
      .data_i    (dd2[k]),
      .divisor_i (npi_q),
      .valid_o   (dv2[k+1]),
      .data_o    (dd2[k+1])
    );
  end

  // Drive result fields by region.
  pl_t res;
  assign res         = dd2[N_DIV2];
  assign out_valid_o = dv2[N_DIV2];
  assign region_o    = res.region;

  always_comb begin
    top_index_o    = '0;
    middle_index_o = '0;
    leaf_index_o   = res.leaf;
    case (res.region)
      REG_INODE, REG_DIRECT0, REG_DIRECT1: ;
      REG_IND0, REG_IND1: begin
        top_index_o = res.a[13:0];
      end
      REG_DIND: begin
        top_index_o    = res.q[13:0];
        middle_index_o = res.a[13:0];
      end
      default: begin
        leaf_index_o = '0;
      end
    endcase
  end

endmodule

[design/fbn_front_stage.sv]
module fbn_front_stage #(
  parameter logic [2:0] CODE = 3'd0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  fbn_pkg::pl_t  data_i,
  input  logic [47:0]   thr_i,
  output logic          valid_o,
  output fbn_pkg::pl_t  data_o
);
  import fbn_pkg::*;

  pl_t  data_d, data_q;
  logic valid_q;

  // Claim the region if the offset falls inside it, else skip past it.
  always_comb begin
    data_d = data_i;
    if (data_i.region == REG_HOLE) begin
      if (data_i.a < thr_i) begin
        data_d.region = CODE;
      end else begin
        data_d.a = data_i.a - thr_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[design/fbn_div_stage.sv]
module fbn_div_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  fbn_pkg::pl_t  data_i,
  input  logic [13:0]   divisor_i,
  output logic          valid_o,
  output fbn_pkg::pl_t  data_o
);
  import fbn_pkg::*;

  pl_t         data_d, data_q;
  logic        valid_q;
  logic [47:0] trial;

  // One restoring step: settle quotient bit SHIFT.
  always_comb begin
    data_d = data_i;
    trial  = 48'(divisor_i) << SHIFT;
    if (data_i.a >= trial) begin
      data_d.a        = data_i.a - trial;
      data_d.q[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[design/fbn_checker.sv]
module fbn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  region_o,
  input logic [13:0] top_index_o,
  input logic [13:0] middle_index_o,
  input logic [13:0] leaf_index_o
);
  import fbn_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting result");

  a_hole_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && region_o == REG_HOLE |->
      top_index_o == '0 && middle_index_o == '0 && leaf_index_o == '0)
    else $error("hole carries nonzero indices");

  a_mid_only_dind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && region_o != REG_DIND |-> middle_index_o == '0)
    else $error("middle index outside double-indirect");

endmodule

bind file_block_index_to_node_path_top fbn_checker u_fbn_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .region_o       (region_o),
  .top_index_o    (top_index_o),
  .middle_index_o (middle_index_o),
  .leaf_index_o   (leaf_index_o)
);

[tb/sv/file_block_index_to_node_path_checker.sv]
`timescale 1ns / 100ps

module file_block_index_to_node_path_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [47:0] block_index_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  region_i,
  input  logic [13:0] top_index_i,
  input  logic [13:0] middle_index_i,
  input  logic [13:0] leaf_index_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i,
  output int          fail_count_o,
  output int          path_count_o,
  output int          pending_o
);
  import fbn_pkg::*;

  typedef struct packed {
    logic [2:0]  region;
    logic [13:0] top;
    logic [13:0] mid;
    logic [13:0] leaf;
  } node_path_t;

  localparam int PATH_DEPTH = 64;

  node_path_t  path_mem [0:PATH_DEPTH-1];
  logic [5:0]  wr_ptr;
  logic [5:0]  rd_ptr;
  int          fill;
  logic [13:0] slots_r;
  logic [13:0] apn_r;
  logic [3:0]  clog_r;

  function automatic node_path_t walk_path(logic [47:0] bidx);
    node_path_t  p;
    logic [63:0] npi, cs, dpd, per_ind, b, r;
    logic [3:0]  cl;
    p = '0;
    p.region = REG_HOLE;
    npi = apn_r;
    cl = (clog_r > CLUSTER_LOG_MAX) ? CLUSTER_LOG_MAX : clog_r;
    cs = 64'd1 << cl;
    dpd = npi - (npi % cs);
    per_ind = npi * dpd;
    if (bidx < slots_r) begin
      p.region = REG_INODE;
      p.leaf = bidx[13:0];
    end else if (dpd != 0) begin
      b = bidx - slots_r;
      if (b < dpd) begin
        p.region = REG_DIRECT0;
        p.leaf = b[13:0];
      end else if (b - dpd < dpd) begin
        p.region = REG_DIRECT1;
        p.leaf = 14'(b - dpd);
      end else begin
        b = b - 2 * dpd;
        if (b < per_ind) begin
          p.region = REG_IND0;
          p.top = 14'(b / dpd);
          p.leaf = 14'(b % dpd);
        end else if (b - per_ind < per_ind) begin
          b = b - per_ind;
          p.region = REG_IND1;
          p.top = 14'(b / dpd);
          p.leaf = 14'(b % dpd);
        end else begin
          b = b - 2 * per_ind;
          if (b < npi * per_ind) begin
            r = b % per_ind;
            p.region = REG_DIND;
            p.top = 14'(b / per_ind);
            p.mid = 14'(r / dpd);
            p.leaf = 14'(r % dpd);
          end
        end
      end
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
    fail_count_o++;
  endtask

  assign pending_o = fill;

  always @(posedge clk_i or negedge rst_ni) begin
    node_path_t want;
    if (!rst_ni) begin
      slots_r <= INODE_SLOTS_RST;
      apn_r <= ADDRS_PER_NODE_RST;
      clog_r <= CLUSTER_LOG_RST;
      wr_ptr = '0;
      rd_ptr = '0;
      fill = 0;
      fail_count_o = 0;
      path_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        path_count_o++;
        if (fill == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          want = path_mem[rd_ptr];
          rd_ptr = rd_ptr + 6'd1;
          fill--;
          if (region_i !== want.region) report_mismatch("region", region_i, want.region);
          if (top_index_i !== want.top) report_mismatch("top_index", top_index_i, want.top);
          if (middle_index_i !== want.mid)
            report_mismatch("middle_index", middle_index_i, want.mid);
          if (leaf_index_i !== want.leaf) report_mismatch("leaf_index", leaf_index_i, want.leaf);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (fill == PATH_DEPTH) begin
          report_mismatch("expected paths overflow", fill, PATH_DEPTH - 1);
        end else begin
          path_mem[wr_ptr] = walk_path(block_index_i);
          wr_ptr = wr_ptr + 6'd1;
          fill++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_INODE_SLOTS: slots_r <= cfg_data_i;
          CFG_ADDRS_PER_NODE: apn_r <= cfg_data_i;
          CFG_CLUSTER_LOG: clog_r <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[tb/sv/file_block_index_to_node_path_top_tb.sv]
`timescale 1ns / 100ps

module file_block_index_to_node_path_top_tb;
  import fbn_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [47:0] block_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  region_o;
  logic [13:0] top_index_o, middle_index_o, leaf_index_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = CFG_INODE_SLOTS;
  logic [13:0] cfg_data_i = '0;
  int          fail_count, path_count, pending;
  int          idle_cycles = 0;
  int          sent_count;

  localparam int LATENCY = 48;
  localparam int WATCHDOG_LIMIT = 2000;

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  file_block_index_to_node_path_top uut (.*);

  file_block_index_to_node_path_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .block_index_i,
    .out_valid_i(out_valid_o), .out_stall_i, .region_i(region_o),
    .top_index_i(top_index_o), .middle_index_i(middle_index_o),
    .leaf_index_i(leaf_index_o), .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .path_count_o(path_count), .pending_o(pending)
  );

  // Watchdog: count cycles with no item moving on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d items pending", pending);
        $display("file_block_index_to_node_path_top regression: fail");
        $finish;
      end
    end
  end

  // Receiver: hold stall for a random number of cycles before each item;
  // some stretches run with no stall at all.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Send one item; hold it until accepted.
  task automatic send_index(logic [47:0] bidx, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    block_index_i <= bidx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
  endtask

  // Drop valid, wait for all paths to drain, then let the pipeline settle.
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [13:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Pick an index spread over all regions for the present geometry.
  function automatic logic [47:0] pick_index(logic [13:0] slots, logic [13:0] apn);
    logic [63:0] n, lim;
    n = apn;
    lim = slots + 2 * n + 2 * n * n + n * n * n;
    case ($urandom_range(0, 7))
      0: return 48'($urandom_range(0, slots + 1));
      1: return 48'(slots + $urandom_range(0, 2 * apn + 2));
      2: return 48'(lim - $urandom_range(0, 2 * apn));
      3: return 48'(lim + $urandom_range(0, 100));
      4: return 48'({$urandom(), $urandom()});
      default: return 48'({$urandom(), $urandom()} % (lim + 2));
    endcase
  endfunction

  initial begin
    logic [13:0] slots, apn;
    logic [3:0]  clog;
    logic [63:0] n, lim;
    sent_count = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset geometry, field extremes and region edges.
    n = ADDRS_PER_NODE_RST;
    lim = INODE_SLOTS_RST + 2 * n + 2 * n * n + n * n * n;
    send_index(48'd0, 1'b0);
    send_index(48'(INODE_SLOTS_RST - 1), 1'b0);
    send_index(48'(INODE_SLOTS_RST), 1'b1);
    send_index(48'(INODE_SLOTS_RST + n), 1'b0);
    send_index(48'(INODE_SLOTS_RST + 2 * n), 1'b0);
    send_index(48'(INODE_SLOTS_RST + 2 * n + n * n), 1'b1);
    send_index(48'(INODE_SLOTS_RST + 2 * n + 2 * n * n), 1'b0);
    send_index(48'(lim - 1), 1'b0);
    send_index(48'(lim), 1'b0);
    send_index({48{1'b1}}, 1'b0);
    send_index(48'hAAAA_AAAA_AAAA, 1'b0);
    send_index(48'h5555_5555_5555, 1'b0);
    drain();

    // Large cluster log, cluster wider than node, zero node size.
    write_cfg(CFG_CLUSTER_LOG, 14'd15);
    send_index(48'd5000, 1'b0);
    send_index(48'd3000000, 1'b0);
    drain();
    write_cfg(CFG_ADDRS_PER_NODE, 14'd122);
    write_cfg(CFG_CLUSTER_LOG, 14'd8);
    send_index(48'd922, 1'b0);
    send_index(48'd923, 1'b0);
    drain();
    write_cfg(CFG_ADDRS_PER_NODE, 14'd0);
    write_cfg(CFG_INODE_SLOTS, 14'd0);
    send_index(48'd0, 1'b0);
    send_index(48'd1, 1'b0);
    drain();

    // Random phases over many geometries, extremes included.
    for (int ph = 0; ph < 19; ph++) begin
      case (ph)
        0: begin slots = 14'd0; apn = 14'd122; clog = 4'd0; end
        1: begin slots = 14'd16283; apn = 14'd16378; clog = 4'd8; end
        2: begin slots = 14'h3FFF; apn = 14'h3FFF; clog = 4'hF; end
        3: begin slots = 14'd0; apn = 14'd16378; clog = 4'd0; end
        default: begin
          slots = 14'($urandom_range(0, 16383));
          apn = ($urandom_range(0, 9) == 0) ? 14'($urandom_range(0, 300)) :
                14'($urandom_range(122, 16383));
          clog = 4'($urandom_range(0, 15));
        end
      endcase
      write_cfg(CFG_INODE_SLOTS, slots);
      write_cfg(CFG_ADDRS_PER_NODE, apn);
      write_cfg(CFG_CLUSTER_LOG, {10'd0, clog});
      for (int k = 0; k < 100; k++) begin
        send_index(pick_index(slots, apn), (k / 25) % 2 == 1);
      end
      drain();
    end

    $display("sent %0d block indices over 23 register settings, %0d paths checked",
             sent_count, path_count);
    if (fail_count == 0 && pending == 0) begin
      $display("file_block_index_to_node_path_top regression: pass");
    end else begin
      $display("file_block_index_to_node_path_top regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
design/fbn_pkg.sv
design/fbn_front_stage.sv
design/fbn_div_stage.sv
design/file_block_index_to_node_path_top.sv
design/fbn_checker.sv
tb/sv/file_block_index_to_node_path_checker.sv
tb/sv/file_block_index_to_node_path_top_tb.sv
